[design/rbe_pkg.sv]
// ----------------------------------------------------------------------------
// rbe_pkg: shared types, constants and functions of the Rijndael encryptor
// Holds the S-box table, GF(2^8) helpers, variant shapes and register codes.
// ----------------------------------------------------------------------------
package rbe_pkg;

    localparam int MAX_BLOCK_WORDS_DEF = 8;
    localparam int NUM_ROWS            = 15;
    localparam int ROW_W               = $clog2(NUM_ROWS);

    // Configuration register indexes
    localparam logic [2:0] REG_VARIANT = 3'd0;
    localparam logic [2:0] REG_KEY0    = 3'd1;
    localparam logic [2:0] REG_KEY1    = 3'd2;
    localparam logic [2:0] REG_KEY2    = 3'd3;
    localparam logic [2:0] REG_KEY3    = 3'd4;

    // Variant codes
    localparam logic [2:0] VAR_AES128 = 3'd0;
    localparam logic [2:0] VAR_AES192 = 3'd1;
    localparam logic [2:0] VAR_AES256 = 3'd2;
    localparam logic [2:0] VAR_RIJ192 = 3'd3;
    localparam logic [2:0] VAR_RIJ256 = 3'd4;

    typedef logic [3:0][63:0] t_blk;

    typedef struct packed {
        logic [3:0] nk;
        logic [3:0] nb;
        logic [3:0] nr;
    } t_shape;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // Unknown codes and blocks wider than the store fall back to AES-128
    function automatic t_shape get_shape(input logic [2:0] v, input int max_words);
        t_shape s;
        s = '{nk: 4'd4, nb: 4'd4, nr: 4'd10};
        unique case (v)
            VAR_AES192: s = '{nk: 4'd6, nb: 4'd4, nr: 4'd12};
            VAR_AES256: s = '{nk: 4'd8, nb: 4'd4, nr: 4'd14};
            VAR_RIJ192: if (max_words >= 6) s = '{nk: 4'd6, nb: 4'd6, nr: 4'd12};
            VAR_RIJ256: if (max_words >= 8) s = '{nk: 4'd8, nb: 4'd8, nr: 4'd14};
            default:    s = '{nk: 4'd4, nb: 4'd4, nr: 4'd10};
        endcase
        return s;
    endfunction

endpackage

[design/rbe_front.sv]
// ----------------------------------------------------------------------------
// rbe_front: input queue
// Two-entry queue that takes plaintext items and hands them to the round engine.
// ----------------------------------------------------------------------------
module rbe_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    output logic          o_full,
    input  rbe_pkg::t_blk i_blk,
    output logic          o_valid,
    output rbe_pkg::t_blk o_blk,
    input  logic          i_pop
);
    import rbe_pkg::*;

    t_blk       r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_blk   = r_q[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // Store item payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= i_blk;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

[design/rbe_key.sv]
// ----------------------------------------------------------------------------
// rbe_key: configuration registers and round-key store
// Expands the key one schedule word per cycle into a row-organized store.
// ----------------------------------------------------------------------------
module rbe_key #(
    parameter int MAX_BLOCK_WORDS = rbe_pkg::MAX_BLOCK_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [2:0]                        i_cfg_index,
    input  logic [63:0]                       i_cfg_data,
    output rbe_pkg::t_shape                   o_shape,
    output logic                              o_ready,
    input  logic [rbe_pkg::ROW_W-1:0]         i_rd_row,
    output logic [MAX_BLOCK_WORDS-1:0][31:0]  o_rd_data
);
    import rbe_pkg::*;

    localparam int CW = $clog2(MAX_BLOCK_WORDS);

    logic [2:0]                      r_variant;
    logic [63:0]                     r_key [4];
    logic [MAX_BLOCK_WORDS-1:0][31:0] r_mem [NUM_ROWS];
    logic [31:0]                     r_win [8];
    logic                            r_busy;
    logic                            r_first;
    logic [2:0]                      r_kmod;
    logic [CW-1:0]                   r_col;
    logic [ROW_W-1:0]                r_row;
    logic [7:0]                      r_rcon;
    t_shape                          w_shape;
    logic [31:0]                     w_t;
    logic [31:0]                     w_word;
    logic [63:0]                     w_kw;
    logic                            w_last;

    assign w_shape = get_shape(r_variant, MAX_BLOCK_WORDS);
    assign o_shape = w_shape;
    assign o_ready = !r_busy;

    // Next schedule word
    always_comb begin
        w_kw = r_key[r_kmod[2:1]];
        w_t  = r_win[0];
        if (r_kmod == 3'd0) begin
            w_t = sub_word({r_win[0][23:0], r_win[0][31:24]}) ^ {r_rcon, 24'd0};
        end else if (w_shape.nk == 4'd8 && r_kmod == 3'd4) begin
            w_t = sub_word(r_win[0]);
        end
        if (r_first) begin
            w_word = r_kmod[0] ? w_kw[31:0] : w_kw[63:32];
        end else begin
            w_word = r_win[3'(w_shape.nk - 4'd1)] ^ w_t;
        end
        w_last = (r_row == ROW_W'(w_shape.nr)) && (r_col == CW'(w_shape.nb - 4'd1));
    end

    // Write registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= VAR_AES128;
            r_key     <= '{default: 64'd0};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_VARIANT: r_variant <= i_cfg_data[2:0];
                REG_KEY0:    r_key[0]  <= i_cfg_data;
                REG_KEY1:    r_key[1]  <= i_cfg_data;
                REG_KEY2:    r_key[2]  <= i_cfg_data;
                REG_KEY3:    r_key[3]  <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // Sequence the expansion; restart after reset and every write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_busy  <= 1'b1;
            r_first <= 1'b1;
            r_kmod  <= 3'd0;
            r_col   <= '0;
            r_row   <= '0;
            r_rcon  <= 8'h01;
        end else if (r_busy) begin
            if (r_kmod == 3'(w_shape.nk - 4'd1)) begin
                r_kmod  <= 3'd0;
                r_first <= 1'b0;
            end else begin
                r_kmod <= r_kmod + 3'd1;
            end
            if (!r_first && r_kmod == 3'd0) r_rcon <= xtime(r_rcon);
            if (r_col == CW'(w_shape.nb - 4'd1)) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + CW'(1);
            end
            if (w_last) r_busy <= 1'b0;
        end
    end

    // Shift window of recent schedule words
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_win[0] <= w_word;
            for (int i = 1; i < 8; i++) r_win[i] <= r_win[i-1];
        end
    end

    // Store write and registered row read
    always_ff @(posedge i_clk) begin
        if (r_busy) r_mem[r_row][r_col] <= w_word;
        o_rd_data <= r_mem[i_rd_row];
    end

endmodule

[design/rbe_core.sv]
// ----------------------------------------------------------------------------
// rbe_core: round engine and result register
// Runs the initial key add, then one round per cycle on the block state, then holds the result.
// ----------------------------------------------------------------------------
module rbe_core #(
    parameter int MAX_BLOCK_WORDS = rbe_pkg::MAX_BLOCK_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  rbe_pkg::t_blk                     i_blk,
    output logic                              o_take,
    input  rbe_pkg::t_shape                   i_shape,
    input  logic                              i_key_ready,
    output logic [rbe_pkg::ROW_W-1:0]         o_rd_row,
    input  logic [MAX_BLOCK_WORDS-1:0][31:0]  i_rk,
    output logic                              o_empty,
    input  logic                              i_pop,
    output rbe_pkg::t_blk                     o_res
);
    import rbe_pkg::*;

    localparam int NBYTES = 4 * MAX_BLOCK_WORDS;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    t_state           r_state;
    logic [ROW_W-1:0] r_round;
    logic [7:0]       r_st [NBYTES];
    logic [7:0]       w_sb [NBYTES];
    logic [7:0]       w_nx [NBYTES];
    logic             r_out_valid;
    t_blk             r_out;
    t_blk             w_res;
    logic             w_last;
    logic [3:0]       w_sh [4];

    assign w_last  = (r_round == ROW_W'(i_shape.nr));
    assign o_take  = (r_state == S_IDLE) && i_valid && i_key_ready && !r_out_valid;
    assign o_empty = !r_out_valid;
    assign o_res   = r_out;

    // Fetch the row for the coming round
    always_comb begin
        o_rd_row = '0;
        if (r_state == S_RUN && !w_last) o_rd_row = r_round + ROW_W'(1);
    end

    // Round 0 adds the key; later rounds substitute, shift rows, mix (not last), add key
    always_comb begin
        logic [3:0] src;
        logic [7:0] a0, a1, a2, a3;
        w_sh[0] = 4'd0;
        w_sh[1] = 4'd1;
        w_sh[2] = (i_shape.nb == 4'd8) ? 4'd3 : 4'd2;
        w_sh[3] = (i_shape.nb == 4'd8) ? 4'd4 : 4'd3;
        for (int c = 0; c < MAX_BLOCK_WORDS; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = 4'(c) + w_sh[r];
                if (src >= i_shape.nb) src = src - i_shape.nb;
                w_sb[4*c+r] = SBOX[r_st[4*int'(src)+r]];
            end
        end
        for (int c = 0; c < MAX_BLOCK_WORDS; c++) begin
            a0 = w_sb[4*c];
            a1 = w_sb[4*c+1];
            a2 = w_sb[4*c+2];
            a3 = w_sb[4*c+3];
            if (r_round == '0) begin
                for (int r = 0; r < 4; r++) w_nx[4*c+r] = r_st[4*c+r];
            end else if (w_last) begin
                w_nx[4*c]   = a0;
                w_nx[4*c+1] = a1;
                w_nx[4*c+2] = a2;
                w_nx[4*c+3] = a3;
            end else begin
                w_nx[4*c]   = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
                w_nx[4*c+1] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
                w_nx[4*c+2] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
                w_nx[4*c+3] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
            end
            for (int r = 0; r < 4; r++) begin
                w_nx[4*c+r] = w_nx[4*c+r] ^ i_rk[c][31-8*r -: 8];
            end
        end
    end

    // Pack the final state; zero bytes beyond the block
    always_comb begin
        w_res = '0;
        for (int i = 0; i < 32; i++) begin
            if (i < NBYTES && i < 4 * int'(i_shape.nb)) begin
                w_res[i/8][63-8*(i%8) -: 8] = w_nx[i];
            end
        end
    end

    // Sequence rounds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_pop && r_out_valid) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (o_take) begin
                        r_round <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_last) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_round <= r_round + ROW_W'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Load and update the block state; capture the result
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            for (int i = 0; i < NBYTES; i++) r_st[i] <= i_blk[i/8][63-8*(i%8) -: 8];
        end else if (r_state == S_RUN) begin
            r_st <= w_nx;
        end
        if (r_state == S_RUN && w_last) r_out <= w_res;
    end

endmodule

[design/rijndael_block_encrypt_unit.sv]
// ----------------------------------------------------------------------------
// rijndael_block_encrypt_unit: Rijndael block encryptor, five variants
// Queue-style input and output around a one-round-per-cycle engine.
// ----------------------------------------------------------------------------
// Each item is one plaintext block; each result is its ciphertext. The engine
// does the initial key add and then one round per cycle, with the single round
// unit reading one round-key row per cycle. One item is in the engine at a
// time; the next waits in a two-entry input queue, and a finished result waits
// in the output register. After reset and after every register write the key
// schedule is rebuilt, one word per cycle; items wait until it is done.
module rijndael_block_encrypt_unit #(
    parameter int MAX_BLOCK_WORDS = rbe_pkg::MAX_BLOCK_WORDS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    input  logic        i_push,
    output logic        o_full,
    input  logic [63:0] i_block_word0,
    input  logic [63:0] i_block_word1,
    input  logic [63:0] i_block_word2,
    input  logic [63:0] i_block_word3,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [63:0] o_cipher_word0,
    output logic [63:0] o_cipher_word1,
    output logic [63:0] o_cipher_word2,
    output logic [63:0] o_cipher_word3
);
    import rbe_pkg::*;

    t_blk                            w_in;
    t_blk                            w_q_blk;
    t_blk                            w_res;
    logic                            w_q_valid;
    logic                            w_take;
    t_shape                          w_shape;
    logic                            w_key_ready;
    logic [ROW_W-1:0]                w_rd_row;
    logic [MAX_BLOCK_WORDS-1:0][31:0] w_rk;

    assign w_in = {i_block_word3, i_block_word2, i_block_word1, i_block_word0};
    assign o_cipher_word0 = w_res[0];
    assign o_cipher_word1 = w_res[1];
    assign o_cipher_word2 = w_res[2];
    assign o_cipher_word3 = w_res[3];

    rbe_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .o_full  (o_full),
        .i_blk   (w_in),
        .o_valid (w_q_valid),
        .o_blk   (w_q_blk),
        .i_pop   (w_take)
    );

    rbe_key #(.MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)) u_key (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_shape     (w_shape),
        .o_ready     (w_key_ready),
        .i_rd_row    (w_rd_row),
        .o_rd_data   (w_rk)
    );

    rbe_core #(.MAX_BLOCK_WORDS(MAX_BLOCK_WORDS)) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_q_valid),
        .i_blk       (w_q_blk),
        .o_take      (w_take),
        .i_shape     (w_shape),
        .i_key_ready (w_key_ready),
        .o_rd_row    (w_rd_row),
        .i_rk        (w_rk),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_res       (w_res)
    );

endmodule

[design/rbe_checker.sv]
// ----------------------------------------------------------------------------
// rbe_checker: port-level checks of the encryptor
// Watches reset behavior, result hold and the result register turnaround.
// ----------------------------------------------------------------------------
module rbe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_full,
    input logic        o_empty,
    input logic        i_pop,
    input logic [63:0] o_cipher_word0
);

    // Reset leaves no result and room for input
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result present after reset");
    a_rst_room: assert property (@(posedge i_clk) !i_rst_n |=> !o_full)
        else $error("input full after reset");

    // Hold a waiting result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> $stable(o_cipher_word0))
        else $error("waiting result changed");

    // A take empties the result register; no new result appears right after it
    a_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && i_pop) |=> o_empty)
        else $error("result appeared right after a take");

endmodule

bind rijndael_block_encrypt_unit rbe_checker u_rbe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_full         (o_full),
    .o_empty        (o_empty),
    .i_pop          (i_pop),
    .o_cipher_word0 (o_cipher_word0)
);
